### sv/sit_pkg.sv
`default_nettype none
package sit_pkg;

   localparam int MAX_MIPS_DEF   = 16;
   localparam int MAX_LAYERS_DEF = 256;

   // Fixed field widths
   localparam int MIP_W       = 4;
   localparam int MIP_CNT_W   = 5;
   localparam int LAYER_W     = 8;
   localparam int LAYER_CNT_W = 9;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;

   localparam logic [CSR_INDEX_W-1:0] CSR_MIP_LEVELS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ARRAY_LAYERS = 2'd1;

   localparam logic REQ_QUERY = 1'b0;
   localparam logic REQ_MARK  = 1'b1;

   typedef struct packed {
      logic rd;
      logic wr;
   } mem_cmd_type;

endpackage
`default_nettype wire

### sv/sit_bitmap.sv
`default_nettype none
module sit_bitmap import sit_pkg::*; #(
   parameter int DEPTH = MAX_MIPS_DEF * MAX_LAYERS_DEF,
   parameter int AW    = 12
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire mem_cmd_type   cmd,
   input  wire logic [AW-1:0] addr,
   output logic               rd_data,
   output logic               ready
);

   logic          mem_q [DEPTH];
   logic          clr_ff, clr_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic          rd_data_ff;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic          wr_bit;

   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   // Sweep the array once after reset, then hand the port to the walker
   assign wr_en   = clr_ff | cmd.wr;
   assign wr_addr = clr_ff ? clr_addr_ff : addr;
   assign wr_bit  = ~clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_q[wr_addr] <= wr_bit;
      end
      if (cmd.rd) begin
         rd_data_ff <= mem_q[addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign ready   = ~clr_ff;

endmodule
`default_nettype wire

### sv/sit_walker.sv
`default_nettype none
module sit_walker import sit_pkg::*; #(
   parameter int AW    = 12,
   parameter int LAY_W = 10
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   go,
   input  wire logic                   req_type,
   input  wire logic [MIP_W-1:0]       base_mip,
   input  wire logic [MIP_CNT_W-1:0]   mip_count,
   input  wire logic [LAYER_W-1:0]     base_layer,
   input  wire logic [LAYER_CNT_W-1:0] layer_count,
   input  wire logic [MIP_CNT_W-1:0]   num_mips,
   input  wire logic [LAY_W-1:0]       num_layers,
   output logic                        busy,
   output mem_cmd_type                 mem_cmd,
   output logic [AW-1:0]               mem_addr,
   input  wire logic                   mem_rd_data,
   output logic                        rsp_valid,
   output logic                        rsp_all,
   output logic                        rsp_err
);

   localparam int SW = (AW > 14) ? AW : 14;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SETUP = 3'd1;
   localparam logic [2:0] ST_BASE  = 3'd2;
   localparam logic [2:0] ST_RUN   = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic                   mark_ff, mark_in;
   logic [MIP_W-1:0]       bm_ff, bm_in;
   logic [MIP_CNT_W-1:0]   mc_ff, mc_in;
   logic [LAYER_W-1:0]     bl_ff, bl_in;
   logic [LAYER_CNT_W-1:0] lc_ff, lc_in;
   logic [SW-1:0]          prod_ff, prod_in;
   logic [SW-1:0]          addr_ff, addr_in;
   logic [SW-1:0]          row_ff, row_in;
   logic [MIP_CNT_W-1:0]   m_left_ff, m_left_in;
   logic [LAYER_CNT_W-1:0] l_left_ff, l_left_in;
   logic                   all_ff, all_in;
   logic                   rd_pend_ff, rd_pend_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_all_ff, rsp_all_in;
   logic                   rsp_err_ff, rsp_err_in;
   logic                   mip_oob, lay_oob, empty;
   logic [SW-1:0]          row_next;
   logic                   last;
   logic                   all_now;

   assign mip_oob  = ({2'b00, bm_ff} + {1'b0, mc_ff}) > {1'b0, num_mips};
   assign lay_oob  = (LAY_W'(bl_ff) + LAY_W'(lc_ff)) > num_layers;
   assign empty    = (mc_ff == '0) | (lc_ff == '0);
   assign row_next = row_ff + SW'(num_mips);
   assign last     = (m_left_ff == MIP_CNT_W'(1)) & (l_left_ff == LAYER_CNT_W'(1));
   assign all_now  = rd_pend_ff ? (all_ff & mem_rd_data) : all_ff;

   always_comb begin
      state_in     = state_ff;
      mark_in      = mark_ff;
      bm_in        = bm_ff;
      mc_in        = mc_ff;
      bl_in        = bl_ff;
      lc_in        = lc_ff;
      prod_in      = prod_ff;
      addr_in      = addr_ff;
      row_in       = row_ff;
      m_left_in    = m_left_ff;
      l_left_in    = l_left_ff;
      all_in       = all_now;
      rd_pend_in   = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_all_in   = rsp_all_ff;
      rsp_err_in   = rsp_err_ff;
      mem_cmd.rd   = 1'b0;
      mem_cmd.wr   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (go) begin
               mark_in  = req_type;
               bm_in    = base_mip;
               mc_in    = mip_count;
               bl_in    = base_layer;
               lc_in    = layer_count;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            prod_in = SW'(num_mips) * SW'(bl_ff);
            if (mip_oob | lay_oob) begin
               rsp_valid_in = 1'b1;
               rsp_all_in   = 1'b0;
               rsp_err_in   = 1'b1;
               state_in     = ST_IDLE;
            end else if (empty) begin
               rsp_valid_in = 1'b1;
               rsp_all_in   = 1'b1;
               rsp_err_in   = 1'b0;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_BASE;
            end
         end
         ST_BASE: begin
            addr_in   = prod_ff + SW'(bm_ff);
            row_in    = prod_ff + SW'(bm_ff);
            m_left_in = mc_ff;
            l_left_in = lc_ff;
            all_in    = 1'b1;
            state_in  = ST_RUN;
         end
         ST_RUN: begin
            mem_cmd.rd = (mark_ff == REQ_QUERY);
            mem_cmd.wr = (mark_ff == REQ_MARK);
            rd_pend_in = (mark_ff == REQ_QUERY);
            // Advance along the mips of a layer, then step to the next layer row
            if (m_left_ff == MIP_CNT_W'(1)) begin
               m_left_in = mc_ff;
               l_left_in = l_left_ff - LAYER_CNT_W'(1);
               row_in    = row_next;
               addr_in   = row_next;
            end else begin
               m_left_in = m_left_ff - MIP_CNT_W'(1);
               addr_in   = addr_ff + SW'(1);
            end
            if (last) begin
               if (mark_ff == REQ_MARK) begin
                  rsp_valid_in = 1'b1;
                  rsp_all_in   = 1'b1;
                  rsp_err_in   = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            rsp_valid_in = 1'b1;
            rsp_all_in   = all_now;
            rsp_err_in   = 1'b0;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mark_ff    <= mark_in;
      bm_ff      <= bm_in;
      mc_ff      <= mc_in;
      bl_ff      <= bl_in;
      lc_ff      <= lc_in;
      prod_ff    <= prod_in;
      addr_ff    <= addr_in;
      row_ff     <= row_in;
      m_left_ff  <= m_left_in;
      l_left_ff  <= l_left_in;
      all_ff     <= all_in;
      rsp_all_ff <= rsp_all_in;
      rsp_err_ff <= rsp_err_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign mem_addr  = addr_ff[AW-1:0];
   assign rsp_valid = rsp_valid_ff;
   assign rsp_all   = rsp_all_ff;
   assign rsp_err   = rsp_err_ff;

endmodule
`default_nettype wire

### sv/subresource_init_tracker.sv
// Channel  | Ports                                     | Handshake
// request  | req_type, req_base_*, req_*_count         | start & !busy
// result   | rsp_all_initialized, rsp_range_error      | rsp_valid, one cycle
// register | csr_index, csr_wdata                      | csr_valid & csr_ready
//
// A query holds busy through setup, base address, a walk of the bitmap one bit
// per cycle through its single port, and one read drain; a mark skips the
// drain. A range error or an empty rectangle ends the request from the setup
// state. The result beat shows in the first cycle with busy low, so the next
// request can be taken then. After reset the bitmap is cleared one bit per
// cycle, and busy stays high until the clear is done. Register writes are
// taken at any time. The result beat cannot be stalled.
`default_nettype none
module subresource_init_tracker import sit_pkg::*; #(
   parameter int MAX_MIPS   = MAX_MIPS_DEF,
   parameter int MAX_LAYERS = MAX_LAYERS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic                   req_type,
   input  wire logic [MIP_W-1:0]       req_base_mip,
   input  wire logic [MIP_CNT_W-1:0]   req_mip_count,
   input  wire logic [LAYER_W-1:0]     req_base_layer,
   input  wire logic [LAYER_CNT_W-1:0] req_layer_count,
   output logic                        rsp_valid,
   output logic                        rsp_all_initialized,
   output logic                        rsp_range_error,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int DEPTH = MAX_MIPS * MAX_LAYERS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LAY_W = ($clog2(MAX_LAYERS + 1) > 10) ? $clog2(MAX_LAYERS + 1) : 10;

   logic [MIP_CNT_W-1:0]   mip_levels_ff, mip_levels_in;
   logic [LAYER_CNT_W-1:0] array_layers_ff, array_layers_in;
   logic [MIP_CNT_W-1:0]   num_mips;
   logic [LAY_W-1:0]       num_layers;
   logic                   walk_busy;
   logic                   mem_ready;
   logic                   go;
   mem_cmd_type            mem_cmd;
   logic [AW-1:0]          mem_addr;
   logic                   mem_rd_data;

   assign csr_ready = 1'b1;

   always_comb begin
      mip_levels_in   = mip_levels_ff;
      array_layers_in = array_layers_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MIP_LEVELS:   mip_levels_in   = csr_wdata[MIP_CNT_W-1:0];
            CSR_ARRAY_LAYERS: array_layers_in = csr_wdata[LAYER_CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mip_levels_ff   <= MIP_CNT_W'(1);
         array_layers_ff <= LAYER_CNT_W'(1);
      end else begin
         mip_levels_ff   <= mip_levels_in;
         array_layers_ff <= array_layers_in;
      end
   end

   // Clamp the counts to the built size
   assign num_mips = (mip_levels_ff > MIP_CNT_W'(MAX_MIPS)) ?
                     MIP_CNT_W'(MAX_MIPS) : mip_levels_ff;
   assign num_layers = (LAY_W'(array_layers_ff) > LAY_W'(MAX_LAYERS)) ?
                       LAY_W'(MAX_LAYERS) : LAY_W'(array_layers_ff);

   assign busy = walk_busy | ~mem_ready;
   assign go   = start & ~busy;

   sit_walker #(
      .AW    (AW),
      .LAY_W (LAY_W)
   ) u_walker (
      .clock       (clock),
      .reset       (reset),
      .go          (go),
      .req_type    (req_type),
      .base_mip    (req_base_mip),
      .mip_count   (req_mip_count),
      .base_layer  (req_base_layer),
      .layer_count (req_layer_count),
      .num_mips    (num_mips),
      .num_layers  (num_layers),
      .busy        (walk_busy),
      .mem_cmd     (mem_cmd),
      .mem_addr    (mem_addr),
      .mem_rd_data (mem_rd_data),
      .rsp_valid   (rsp_valid),
      .rsp_all     (rsp_all_initialized),
      .rsp_err     (rsp_range_error)
   );

   sit_bitmap #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_bitmap (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mem_cmd),
      .addr    (mem_addr),
      .rd_data (mem_rd_data),
      .ready   (mem_ready)
   );

endmodule
`default_nettype wire
